[hdl/itep_pkg.sv]
// Package for the interrupt table entry parser.
// Holds result kind codes, entry type codes, list limits and the shared record types.
// No dependencies.
package itep_pkg;

	// List capacities
	localparam int MAX_CPUS     = 64;
	localparam int MAX_IO_CTRLS = 16;
	localparam int MAX_REMAPS   = 16;

	// Counter widths and the largest value each can hold
	localparam int CPU_CNT_W  = 7;
	localparam int LIST_CNT_W = 5;
	localparam int CPU_CNT_MAX  = (1 << CPU_CNT_W) - 1;
	localparam int LIST_CNT_MAX = (1 << LIST_CNT_W) - 1;

	// A list is full at the smaller of its capacity and its counter range
	localparam logic [CPU_CNT_W-1:0] CPU_LIMIT =
		CPU_CNT_W'((MAX_CPUS < CPU_CNT_MAX) ? MAX_CPUS : CPU_CNT_MAX);
	localparam logic [LIST_CNT_W-1:0] CTRL_LIMIT =
		LIST_CNT_W'((MAX_IO_CTRLS < LIST_CNT_MAX) ? MAX_IO_CTRLS : LIST_CNT_MAX);
	localparam logic [LIST_CNT_W-1:0] REMAP_LIMIT =
		LIST_CNT_W'((MAX_REMAPS < LIST_CNT_MAX) ? MAX_REMAPS : LIST_CNT_MAX);

	// Captured field bytes: entry bytes 2..15
	localparam int FIELD_BYTES = 14;

	// Entry type bytes
	localparam logic [7:0] TYPE_LCPU  = 8'd0;
	localparam logic [7:0] TYPE_IOC   = 8'd1;
	localparam logic [7:0] TYPE_OVR   = 8'd2;
	localparam logic [7:0] TYPE_X2CPU = 8'd9;

	// Minimum entry lengths per type
	localparam logic [7:0] LEN_LCPU  = 8'd8;
	localparam logic [7:0] LEN_IOC   = 8'd12;
	localparam logic [7:0] LEN_OVR   = 8'd10;
	localparam logic [7:0] LEN_X2CPU = 8'd16;

	// Smallest legal length: type byte plus length byte
	localparam logic [7:0] LEN_HEADER = 8'd2;

	// Result kinds
	typedef enum logic [2:0] {
		KIND_END   = 3'd0,
		KIND_LCPU  = 3'd1,
		KIND_X2CPU = 3'd2,
		KIND_IOC   = 3'd3,
		KIND_OVR   = 3'd4,
		KIND_STOP  = 3'd5
	} kind_t;

	// Per-byte outcome from the entry assembler
	typedef struct packed {
		logic        emit;
		logic        done;
		kind_t       kind;
		logic [31:0] unit_id;
		logic [31:0] firmware_uid;
		logic [31:0] address_or_pin;
		logic [31:0] pin_base;
		logic [31:0] entry_flags;
		logic        usable;
	} entry_rec_t;

	// List bookkeeping for the same byte
	typedef struct packed {
		logic [5:0]           slot;
		logic                 overflow;
		logic [CPU_CNT_W-1:0] cpu_total;
		logic [CPU_CNT_W-1:0] usable_total;
	} count_res_t;

endpackage

[hdl/itep_assembler.sv]
// Entry assembler: tracks position in the current entry, captures field bytes
// and decodes a completed entry into a record. Uses itep_pkg.
module itep_assembler import itep_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] table_byte,
	input  logic       last,
	output entry_rec_t rec
);

	logic [7:0] pos_q;
	logic [7:0] type_q;
	logic [7:0] len_q;
	logic       halted_q;
	logic [7:0] field_q [FIELD_BYTES];

	logic [7:0] view [FIELD_BYTES];
	logic [7:0] idx;
	logic [8:0] pos_inc;
	logic [7:0] len_eff;
	logic       in_fields;
	logic       complete;
	logic       short_len;
	logic       is_lcpu, is_x2, is_ioc, is_ovr, record;

	assign idx       = pos_q - 8'd2;
	assign pos_inc   = {1'b0, pos_q} + 9'd1;
	assign in_fields = !halted_q && (pos_q >= 8'd2);
	assign len_eff   = (pos_q == 8'd1) ? table_byte : len_q;

	// Field view with the incoming byte merged in
	always_comb begin
		for (int i = 0; i < FIELD_BYTES; i++) begin
			view[i] = (in_fields && idx == 8'(i)) ? table_byte : field_q[i];
		end
	end

	// Entry end and malformed length detection
	assign short_len = !halted_q && (pos_q == 8'd1) && (table_byte < LEN_HEADER);
	assign complete  = !halted_q &&
		(((pos_q == 8'd1) && (table_byte == LEN_HEADER)) ||
		 (in_fields && (pos_inc >= {1'b0, len_q})));

	assign is_lcpu = (type_q == TYPE_LCPU)  && (len_eff >= LEN_LCPU);
	assign is_x2   = (type_q == TYPE_X2CPU) && (len_eff >= LEN_X2CPU);
	assign is_ioc  = (type_q == TYPE_IOC)   && (len_eff >= LEN_IOC);
	assign is_ovr  = (type_q == TYPE_OVR)   && (len_eff >= LEN_OVR);
	assign record  = complete && (is_lcpu || is_x2 || is_ioc || is_ovr);

	// Record decode
	always_comb begin
		rec = '0;
		rec.emit = record || short_len || last;
		rec.done = last;
		rec.kind = KIND_END;
		if (short_len) begin
			rec.kind = KIND_STOP;
		end else if (record) begin
			if (is_lcpu) begin
				rec.kind         = KIND_LCPU;
				rec.firmware_uid = {24'd0, view[0]};
				rec.unit_id      = {24'd0, view[1]};
				rec.entry_flags  = {view[5], view[4], view[3], view[2]};
				rec.usable       = view[2][0];
			end else if (is_x2) begin
				rec.kind         = KIND_X2CPU;
				rec.unit_id      = {view[5], view[4], view[3], view[2]};
				rec.entry_flags  = {view[9], view[8], view[7], view[6]};
				rec.firmware_uid = {view[13], view[12], view[11], view[10]};
				rec.usable       = view[6][0];
			end else if (is_ioc) begin
				rec.kind           = KIND_IOC;
				rec.unit_id        = {24'd0, view[0]};
				rec.address_or_pin = {view[5], view[4], view[3], view[2]};
				rec.pin_base       = {view[9], view[8], view[7], view[6]};
			end else begin
				rec.kind           = KIND_OVR;
				rec.unit_id        = {24'd0, view[1]};
				rec.address_or_pin = {view[5], view[4], view[3], view[2]};
				rec.entry_flags    = {16'd0, view[7], view[6]};
			end
		end
	end

	// Entry tracking state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			type_q   <= '0;
			len_q    <= '0;
			halted_q <= 1'b0;
		end else if (step) begin
			if (!halted_q) begin
				if (pos_q == 8'd0) begin
					type_q <= table_byte;
					pos_q  <= 8'd1;
				end else if (pos_q == 8'd1) begin
					len_q <= table_byte;
					if (table_byte < LEN_HEADER) begin
						halted_q <= 1'b1;
					end else if (table_byte == LEN_HEADER) begin
						pos_q <= 8'd0;
					end else begin
						pos_q <= 8'd2;
					end
				end else if (complete) begin
					pos_q <= 8'd0;
				end else begin
					pos_q <= pos_inc[7:0];
				end
			end
			if (last) begin
				pos_q    <= 8'd0;
				halted_q <= 1'b0;
			end
		end
	end

	// Field byte capture
	always_ff @(posedge clk) begin
		if (step) begin
			for (int i = 0; i < FIELD_BYTES; i++) begin
				field_q[i] <= view[i];
			end
		end
	end

endmodule

[hdl/itep_counter.sv]
// List counters: assigns slots, flags full lists and keeps processor totals.
// Uses itep_pkg.
module itep_counter import itep_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  entry_rec_t rec,
	output count_res_t res
);

	logic [CPU_CNT_W-1:0]  cpu_q, usable_q, cpu_d, usable_d;
	logic [LIST_CNT_W-1:0] ctrl_q, remap_q, ctrl_d, remap_d;
	logic                  is_cpu, is_ioc, is_ovr;

	assign is_cpu = rec.emit && (rec.kind == KIND_LCPU || rec.kind == KIND_X2CPU);
	assign is_ioc = rec.emit && (rec.kind == KIND_IOC);
	assign is_ovr = rec.emit && (rec.kind == KIND_OVR);

	// Slot assignment and full check
	always_comb begin
		cpu_d        = cpu_q;
		usable_d     = usable_q;
		ctrl_d       = ctrl_q;
		remap_d      = remap_q;
		res.slot     = '0;
		res.overflow = 1'b0;
		if (is_cpu) begin
			if (cpu_q >= CPU_LIMIT) begin
				res.overflow = 1'b1;
			end else begin
				res.slot = cpu_q[5:0];
				cpu_d    = cpu_q + 1'b1;
				if (rec.usable) begin
					usable_d = usable_q + 1'b1;
				end
			end
		end else if (is_ioc) begin
			if (ctrl_q >= CTRL_LIMIT) begin
				res.overflow = 1'b1;
			end else begin
				res.slot = 6'(ctrl_q);
				ctrl_d   = ctrl_q + 1'b1;
			end
		end else if (is_ovr) begin
			if (remap_q >= REMAP_LIMIT) begin
				res.overflow = 1'b1;
			end else begin
				res.slot = 6'(remap_q);
				remap_d  = remap_q + 1'b1;
			end
		end
		res.cpu_total    = cpu_d;
		res.usable_total = usable_d;
	end

	// Counter registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpu_q    <= '0;
			usable_q <= '0;
			ctrl_q   <= '0;
			remap_q  <= '0;
		end else if (step) begin
			cpu_q    <= cpu_d;
			usable_q <= usable_d;
			ctrl_q   <= ctrl_d;
			remap_q  <= remap_d;
		end
	end

endmodule

[hdl/interrupt_table_entry_parser.sv]
// Top level of the interrupt table entry parser: input register, entry
// assembler, list counters and result register. Uses itep_pkg, itep_assembler, itep_counter.
//
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------------------------
//  input    | in_valid, in_stall  | table_byte, last
//  result   | out_valid,out_stall | kind, slot, unit_id, firmware_uid,
//           |                     | address_or_pin, pin_base, entry_flags,
//           |                     | usable, overflow, done_res, cpu_total,
//           |                     | usable_total
//
// One byte per cycle sustained while out_stall is low. A result is registered as its
// byte leaves the input register; only recognised entries, bad lengths and last bytes give one.
// Reset clears entry position, halt flag and all list counts.
// A stalled result holds the output register and the input register; the
// input stalls only while both are occupied.
module interrupt_table_entry_parser import itep_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  table_byte,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [5:0]  slot,
	output logic [31:0] unit_id,
	output logic [31:0] firmware_uid,
	output logic [31:0] address_or_pin,
	output logic [31:0] pin_base,
	output logic [31:0] entry_flags,
	output logic        usable,
	output logic        overflow,
	output logic        done_res,
	output logic [6:0]  cpu_total,
	output logic [6:0]  usable_total
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       advance, step, accept;
	entry_rec_t rec;
	count_res_t cnt;

	logic        valid_s2;
	entry_rec_t  rec_s2;
	count_res_t  cnt_s2;

	// Handshake: the byte in the input register moves on when the result register is empty or not stalled
	assign advance  = !valid_s2 || !out_stall;
	assign step     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= table_byte;
			last_s1 <= last;
		end
	end

	itep_assembler u_assembler (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.table_byte (byte_s1),
		.last       (last_s1),
		.rec        (rec)
	);

	itep_counter u_counter (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.rec    (rec),
		.res    (cnt)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= step && rec.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && rec.emit) begin
			rec_s2 <= rec;
			cnt_s2 <= cnt;
		end
	end

	assign out_valid      = valid_s2;
	assign kind           = rec_s2.kind;
	assign slot           = cnt_s2.slot;
	assign unit_id        = rec_s2.unit_id;
	assign firmware_uid   = rec_s2.firmware_uid;
	assign address_or_pin = rec_s2.address_or_pin;
	assign pin_base       = rec_s2.pin_base;
	assign entry_flags    = rec_s2.entry_flags;
	assign usable         = rec_s2.usable;
	assign overflow       = cnt_s2.overflow;
	assign done_res       = rec_s2.done;
	assign cpu_total      = cnt_s2.cpu_total;
	assign usable_total   = cnt_s2.usable_total;

endmodule
